// File: rtl/core/can_id_frequency_signature_defines.svh
// assertion macros for the can identifier frequency signature block
// used by the controller and datapath, needs a clock named clock and a reset named reset
`ifndef CAN_ID_FREQUENCY_SIGNATURE_DEFINES_SVH
`define CAN_ID_FREQUENCY_SIGNATURE_DEFINES_SVH

// same-cycle implication
`define CIFS_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cifs assertion failed");

// next-cycle implication
`define CIFS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cifs assertion failed");

`endif

// File: rtl/core/cifs_pkg.sv
// shared types and constants of the can identifier frequency signature block
// no dependencies
package cifs_pkg;

   localparam int unsigned IdentWidth = 29;
   localparam int unsigned HitsWidth  = 16;
   localparam int unsigned SigWidth   = 32;
   localparam int unsigned UsedWidth  = 6;

   localparam logic [IdentWidth-1:0] ObdBroadcastId = 29'h7DF;
   localparam logic [IdentWidth-1:0] ObdReplyLowId  = 29'h7E8;
   localparam logic [IdentWidth-1:0] ObdReplyHighId = 29'h7EF;
   localparam logic [SigWidth-1:0]   SigSeed        = 32'hDEADBEEF;

   localparam logic KindFrame   = 1'b0;
   localparam logic KindRequest = 1'b1;

   typedef struct packed {
      logic                  kind;
      logic [IdentWidth-1:0] can_id;
   } req_type;

   typedef struct packed {
      logic [SigWidth-1:0]  signature;
      logic [UsedWidth-1:0] used_entries;
   } rsp_type;

   typedef struct packed {
      logic [IdentWidth-1:0] ident;
      logic [HitsWidth-1:0]  hits;
   } entry_type;

   typedef struct packed {
      logic capture;
      logic rd_use_a;
      logic hit_wr;
      logic append;
      logic idx_b_inc;
      logic idx_b_from_a;
      logic cap_cur;
      logic swap;
      logic wr_a;
      logic acc;
      logic idx_a_inc;
   } cmd_type;

   typedef struct packed {
      logic obd;
      logic occ_zero;
      logic id_match;
      logic greater;
      logic a_last;
      logic b_last;
   } status_type;

endpackage

// File: rtl/core/cifs_datapath.sv
// datapath: entry memory, counters, signature accumulator
// depends on cifs_pkg and can_id_frequency_signature_defines.svh
`include "can_id_frequency_signature_defines.svh"

module cifs_datapath #(
   parameter int unsigned TABLE_DEPTH = 32,
   parameter int unsigned RANK_COUNT  = 5
) (
   input  logic                clock,
   input  logic                reset,
   input  cifs_pkg::req_type   req_data,
   input  cifs_pkg::cmd_type   cmd,
   output cifs_pkg::status_type status,
   output cifs_pkg::rsp_type   rsp_data
);
   import cifs_pkg::*;

   localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

   entry_type mem [TABLE_DEPTH];
   entry_type rd_data_ff;
   entry_type cur_ff, cur_in;

   logic [IdentWidth-1:0] id_ff, id_in;
   logic [CW-1:0]         occ_ff, occ_in;
   logic [CW-1:0]         idx_a_ff, idx_a_in;
   logic [CW-1:0]         idx_b_ff, idx_b_in;
   logic [SigWidth-1:0]   sig_ff, sig_in;
   logic [SigWidth-1:0]   prod_ff, prod_in;

   logic                  full;
   logic [CW-1:0]         a_plus, b_plus;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr, rd_addr;
   entry_type             wr_data;

   assign full   = (occ_ff == CW'(TABLE_DEPTH));
   assign a_plus = idx_a_ff + CW'(1);
   assign b_plus = idx_b_ff + CW'(1);

   assign rd_addr = cmd.rd_use_a ? idx_a_ff[AW-1:0] : idx_b_ff[AW-1:0];

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_b_ff[AW-1:0];
      wr_data = cur_ff;
      priority if (cmd.hit_wr) begin
         wr_en        = 1'b1;
         wr_data.ident = rd_data_ff.ident;
         wr_data.hits  = rd_data_ff.hits + HitsWidth'(1);
      end else if (cmd.append) begin
         wr_en         = !full;
         wr_addr       = occ_ff[AW-1:0];
         wr_data.ident = id_ff;
         wr_data.hits  = HitsWidth'(1);
      end else if (cmd.swap) begin
         wr_en = 1'b1;
      end else if (cmd.wr_a) begin
         wr_en   = 1'b1;
         wr_addr = idx_a_ff[AW-1:0];
      end else begin
         wr_en = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      id_in    = cmd.capture ? req_data.can_id : id_ff;
      occ_in   = (cmd.append && !full) ? occ_ff + CW'(1) : occ_ff;
      idx_a_in = idx_a_ff;
      idx_b_in = idx_b_ff;
      cur_in   = cur_ff;
      sig_in   = sig_ff;
      prod_in  = prod_ff;
      if (cmd.capture) begin
         idx_a_in = '0;
         idx_b_in = '0;
         sig_in   = SigSeed;
      end
      if (cmd.idx_a_inc) begin
         idx_a_in = a_plus;
      end
      if (cmd.idx_b_inc) begin
         idx_b_in = b_plus;
      end
      if (cmd.idx_b_from_a) begin
         idx_b_in = a_plus;
      end
      if (cmd.cap_cur || cmd.swap) begin
         cur_in = rd_data_ff;
      end
      if (cmd.wr_a) begin
         prod_in = SigWidth'(SigWidth'(cur_ff.ident) * SigWidth'(a_plus));
      end
      if (cmd.acc && (32'(idx_a_ff) < 32'(RANK_COUNT))) begin
         sig_in = sig_ff ^ prod_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
      id_ff    <= id_in;
      idx_a_ff <= idx_a_in;
      idx_b_ff <= idx_b_in;
      cur_ff   <= cur_in;
      sig_ff   <= sig_in;
      prod_ff  <= prod_in;
   end

   always_comb begin
      status.obd      = (id_ff == ObdBroadcastId) ||
                        ((id_ff >= ObdReplyLowId) && (id_ff <= ObdReplyHighId));
      status.occ_zero = (occ_ff == '0);
      status.id_match = (rd_data_ff.ident == id_ff);
      status.greater  = (rd_data_ff.hits > cur_ff.hits);
      status.a_last   = (a_plus == occ_ff);
      status.b_last   = (b_plus == occ_ff);
   end

   assign rsp_data.signature    = sig_ff;
   assign rsp_data.used_entries = UsedWidth'(occ_ff);

   `CIFS_ASSERT_NOW(occ_in_range, 1'b1, occ_ff <= CW'(TABLE_DEPTH))
   `CIFS_ASSERT_NEXT(append_grows, cmd.append && !full, occ_ff == $past(occ_ff) + CW'(1))

endmodule

// File: rtl/core/cifs_ctrl.sv
// controller state machine sequencing lookup, sort and signature
// depends on cifs_pkg and can_id_frequency_signature_defines.svh
`include "can_id_frequency_signature_defines.svh"

module cifs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 req_kind,
   input  cifs_pkg::status_type status,
   output cifs_pkg::cmd_type    cmd,
   output logic                 busy,
   output logic                 rsp_strobe
);
   import cifs_pkg::*;

   typedef enum logic [10:0] {
      ST_IDLE     = 11'b00000000001,
      ST_FR_CHECK = 11'b00000000010,
      ST_LK_RD    = 11'b00000000100,
      ST_LK_CMP   = 11'b00000001000,
      ST_SR_RD_A  = 11'b00000010000,
      ST_SR_CAP_A = 11'b00000100000,
      ST_SR_RD_B  = 11'b00001000000,
      ST_SR_CMP_B = 11'b00010000000,
      ST_SR_WR_A  = 11'b00100000000,
      ST_SR_ACC   = 11'b01000000000,
      ST_SR_DONE  = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = (state_ff == ST_SR_DONE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               if (req_kind == KindRequest) begin
                  state_in = status.occ_zero ? ST_SR_DONE : ST_SR_RD_A;
               end else begin
                  state_in = ST_FR_CHECK;
               end
            end
         end
         ST_FR_CHECK: begin
            if (status.obd) begin
               state_in = ST_IDLE;
            end else if (status.occ_zero) begin
               cmd.append = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               state_in = ST_LK_RD;
            end
         end
         ST_LK_RD: begin
            state_in = ST_LK_CMP;
         end
         ST_LK_CMP: begin
            if (status.id_match) begin
               cmd.hit_wr = 1'b1;
               state_in   = ST_IDLE;
            end else if (status.b_last) begin
               cmd.append = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               cmd.idx_b_inc = 1'b1;
               state_in      = ST_LK_RD;
            end
         end
         ST_SR_RD_A: begin
            cmd.rd_use_a     = 1'b1;
            cmd.idx_b_from_a = 1'b1;
            state_in         = ST_SR_CAP_A;
         end
         ST_SR_CAP_A: begin
            cmd.cap_cur = 1'b1;
            state_in    = status.a_last ? ST_SR_WR_A : ST_SR_RD_B;
         end
         ST_SR_RD_B: begin
            state_in = ST_SR_CMP_B;
         end
         ST_SR_CMP_B: begin
            cmd.swap = status.greater;
            if (status.b_last) begin
               state_in = ST_SR_WR_A;
            end else begin
               cmd.idx_b_inc = 1'b1;
               state_in      = ST_SR_RD_B;
            end
         end
         ST_SR_WR_A: begin
            cmd.wr_a = 1'b1;
            state_in = ST_SR_ACC;
         end
         ST_SR_ACC: begin
            cmd.acc = 1'b1;
            if (status.a_last) begin
               state_in = ST_SR_DONE;
            end else begin
               cmd.idx_a_inc = 1'b1;
               state_in      = ST_SR_RD_A;
            end
         end
         ST_SR_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `CIFS_ASSERT_NEXT(strobe_single, rsp_strobe, !rsp_strobe && !busy)
   `CIFS_ASSERT_NEXT(accept_goes_busy, start && !busy, busy)
   `CIFS_ASSERT_NOW(one_write_per_cycle, 1'b1, $onehot0({cmd.hit_wr, cmd.append, cmd.swap, cmd.wr_a}))

endmodule

// File: rtl/core/can_id_frequency_signature.sv
// top level of the can identifier frequency signature block
// instantiates cifs_ctrl and cifs_datapath, depends on cifs_pkg
//
// A transaction is taken when start is high and busy is low; busy stays high until the
// block can take the next one. A frame identifier that is an OBD id, or that comes while
// the table is empty, is settled in the check state; otherwise the entries are read in
// turn until one matches or the last is reached, through the entry memory with one
// registered read per cycle. A signature request sweeps the table with an exchange sort
// through that same read and ends with rsp_strobe high for exactly one cycle, carrying
// the signature and used count. The receiver cannot stall: the rsp_ ports hold the result
// from the strobe cycle only until the next transaction is started.
module can_id_frequency_signature #(
   parameter int unsigned TABLE_DEPTH = 32,
   parameter int unsigned RANK_COUNT  = 5
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  cifs_pkg::req_type req_data,
   output logic              rsp_strobe,
   output cifs_pkg::rsp_type rsp_data
);
   import cifs_pkg::*;

   cmd_type    cmd;
   status_type status;

   cifs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_kind   (req_data.kind),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   cifs_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .RANK_COUNT  (RANK_COUNT)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule
